// File: hw/rtl/dst_pkg.sv
// Shared types and constants of the device slot table.
`timescale 1ns / 1ps

package dst_pkg;

  // Entry layout and fixed words
  localparam logic [15:0] MARKER     = 16'hDEAD;
  localparam logic [15:0] EN_BIT     = 16'h8000;
  localparam logic [15:0] ID_LIMIT   = 16'h7FFF;
  localparam logic [15:0] AUTO_RESET = 16'hFFFF;
  localparam int          NUM_AUTO   = 6;

  // Request kinds; the fourth code is unused and reports not found
  typedef enum logic [1:0] {
    KIND_REGISTER = 2'd0,
    KIND_SET      = 2'd1,
    KIND_INIT     = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_ALLOC    = 3'd1,
    ST_FULL     = 3'd2,
    ST_SET      = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_INIT     = 3'd5
  } status_e;

  // Source of a table write
  typedef enum logic [1:0] {
    WR_REBUILD = 2'd0,
    WR_ALLOC   = 2'd1,
    WR_SET     = 2'd2
  } wr_src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    req_load;
    logic    scan_clr;
    logic    rd_en;
    logic    cmp_en;
    logic    valid_clr;
    logic    wr_en;
    wr_src_e wr_src;
    logic    finish;
    status_e fin_status;
  } dst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    kind_e kind;
    logic  marker_ok;
    logic  hit;
    logic  free_seen;
  } dst_sts_t;

endpackage

// File: hw/rtl/dst_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module dst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hw/rtl/dst_datapath.sv
// Datapath: auto registers, request word, entry store, compare and result registers.
`timescale 1ns / 1ps

module dst_datapath #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic [1:0]                       kind_i,
  input  logic [15:0]                      device_word_i,
  input  logic                             want_enabled_i,
  input  dst_pkg::dst_cmd_t                cmd_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr_i,
  input  logic [2:0]                       reb_addr_i,
  output dst_pkg::dst_sts_t                sts_o,
  output logic [2:0]                       status_o,
  output logic [5:0]                       slot_o,
  output logic                             is_enabled_o,
  output logic                             done_o
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  logic [15:0]        auto_q [dst_pkg::NUM_AUTO];
  logic [1:0]         kind_q;
  logic [15:0]        word_q;
  logic               want_q;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [IW-1:0]      rd_addr_q;
  logic [IW-1:0]      free_idx_q;
  logic               free_seen_q;
  logic [15:0]        ram_rdata;
  logic [15:0]        entry;
  logic               match;
  logic               is_free;
  logic [IW-1:0]      wr_addr;
  logic [15:0]        wr_data;
  logic [15:0]        auto_val;
  logic [2:0]         status_q;
  logic [5:0]         slot_q;
  logic               en_q;
  logic               done_q;

  // Configuration registers; indices beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dst_pkg::NUM_AUTO; i++) begin
        auto_q[i] <= dst_pkg::AUTO_RESET;
      end
    end else if (cfg_we_i && (cfg_index_i < 3'(dst_pkg::NUM_AUTO))) begin
      auto_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Request word latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      kind_q <= kind_i;
      word_q <= device_word_i;
      want_q <= want_enabled_i;
    end
  end

  // Entry read, masked by the valid bit so unwritten entries read as zero
  assign entry   = valid_q[rd_addr_q] ? ram_rdata : 16'h0000;
  assign match   = (entry[14:0] == word_q[14:0]);
  assign is_free = (entry[14:0] == 15'd0);

  // Write address and data
  assign auto_val = auto_q[3'(reb_addr_i - 3'd1)];
  always_comb begin
    wr_addr = IW'(reb_addr_i);
    wr_data = dst_pkg::MARKER;
    case (cmd_i.wr_src)
      dst_pkg::WR_REBUILD: begin
        wr_addr = IW'(reb_addr_i);
        if (reb_addr_i == 3'd0) begin
          wr_data = dst_pkg::MARKER;
        end else if (auto_val < dst_pkg::ID_LIMIT) begin
          wr_data = auto_val | dst_pkg::EN_BIT;
        end else begin
          wr_data = 16'h0000;
        end
      end
      dst_pkg::WR_ALLOC: begin
        wr_addr = free_idx_q;
        wr_data = {1'b0, word_q[14:0]};
      end
      dst_pkg::WR_SET: begin
        wr_addr = rd_addr_q;
        wr_data = want_q ? (word_q | dst_pkg::EN_BIT) : word_q;
      end
      default: begin
        wr_addr = IW'(reb_addr_i);
        wr_data = dst_pkg::MARKER;
      end
    endcase
  end

  // Valid bits: a rebuild clears them all, a write sets one
  always_comb begin
    valid_d = cmd_i.valid_clr ? '0 : valid_q;
    if (cmd_i.wr_en) begin
      valid_d[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      free_seen_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_q  <= cmd_i.finish;
      if (cmd_i.scan_clr) begin
        free_seen_q <= 1'b0;
      end else if (cmd_i.cmp_en && is_free && !free_seen_q) begin
        free_seen_q <= 1'b1;
      end
    end
  end

  // Read address tag and first free slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_addr_q <= rd_addr_i;
    end
    if (cmd_i.cmp_en && is_free && !free_seen_q) begin
      free_idx_q <= rd_addr_q;
    end
  end

  dst_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // Result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= cmd_i.fin_status;
      case (cmd_i.fin_status)
        dst_pkg::ST_FOUND: begin
          slot_q <= 6'(rd_addr_q);
          en_q   <= entry[15];
        end
        dst_pkg::ST_ALLOC: begin
          slot_q <= 6'(free_idx_q);
          en_q   <= 1'b0;
        end
        default: begin
          slot_q <= 6'd0;
          en_q   <= 1'b0;
        end
      endcase
    end
  end

  assign sts_o.kind      = dst_pkg::kind_e'(kind_q);
  assign sts_o.marker_ok = (entry == dst_pkg::MARKER);
  assign sts_o.hit       = match;
  assign sts_o.free_seen = free_seen_q;

  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign is_enabled_o = en_q;
  assign done_o       = done_q;

  // Results never come in adjacent cycles
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

  // An allocation writes only a slot the scan found free
  a_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && cmd_i.wr_src == dst_pkg::WR_ALLOC) |-> free_seen_q)
    else $error("allocation without a free slot");

  // A status write lands only on the entry that matched
  a_set_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && cmd_i.wr_src == dst_pkg::WR_SET) |-> match)
    else $error("status write without a matching entry");

endmodule

// File: hw/rtl/dst_controller.sv
// Controller: request sequencing, marker check, rebuild and table scan.
`timescale 1ns / 1ps

module dst_controller #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  dst_pkg::dst_sts_t                sts_i,
  output dst_pkg::dst_cmd_t                cmd_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr_o,
  output logic [2:0]                       reb_addr_o
);

  localparam int            IW   = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);
  localparam logic [2:0]    REB_LAST = 3'(dst_pkg::NUM_AUTO);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_MRD,
    S_MCHK,
    S_REB,
    S_SCAN,
    S_END
  } state_e;

  state_e        state_q;
  logic [IW-1:0] issue_q;
  logic          issue_vld_q;
  logic          cmp_vld_q;
  logic          cmp_last_q;
  logic [2:0]    reb_q;
  logic          scan_hit;

  assign scan_hit = cmp_vld_q && sts_i.hit;

  // Command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.wr_src     = dst_pkg::WR_REBUILD;
    cmd_o.fin_status = dst_pkg::ST_NOTFOUND;
    rd_addr_o        = issue_q;
    reb_addr_o       = reb_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.req_load = start;
        cmd_o.scan_clr = start;
      end
      S_MRD: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = '0;
      end
      S_REB: begin
        cmd_o.valid_clr = (reb_q == 3'd0);
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_src    = dst_pkg::WR_REBUILD;
        if (reb_q == REB_LAST && sts_i.kind == dst_pkg::KIND_INIT) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = dst_pkg::ST_INIT;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en  = issue_vld_q;
        cmd_o.cmp_en = cmp_vld_q;
        if (scan_hit) begin
          cmd_o.finish = 1'b1;
          if (sts_i.kind == dst_pkg::KIND_REGISTER) begin
            cmd_o.fin_status = dst_pkg::ST_FOUND;
          end else begin
            cmd_o.wr_en      = 1'b1;
            cmd_o.wr_src     = dst_pkg::WR_SET;
            cmd_o.fin_status = dst_pkg::ST_SET;
          end
        end
      end
      S_END: begin
        cmd_o.finish = 1'b1;
        if (sts_i.kind == dst_pkg::KIND_REGISTER) begin
          if (sts_i.free_seen) begin
            cmd_o.wr_en      = 1'b1;
            cmd_o.wr_src     = dst_pkg::WR_ALLOC;
            cmd_o.fin_status = dst_pkg::ST_ALLOC;
          end else begin
            cmd_o.fin_status = dst_pkg::ST_FULL;
          end
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

  // State and scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= '0;
      issue_vld_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
      cmp_last_q  <= 1'b0;
      reb_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          reb_q       <= '0;
          issue_q     <= IW'(1);
          issue_vld_q <= 1'b1;
          cmp_vld_q   <= 1'b0;
          case (sts_i.kind)
            dst_pkg::KIND_REGISTER: state_q <= S_MRD;
            dst_pkg::KIND_SET:      state_q <= S_SCAN;
            dst_pkg::KIND_INIT:     state_q <= S_REB;
            default:                state_q <= S_END;
          endcase
        end
        S_MRD: begin
          state_q <= S_MCHK;
        end
        S_MCHK: begin
          state_q <= sts_i.marker_ok ? S_SCAN : S_REB;
        end
        S_REB: begin
          if (reb_q == REB_LAST) begin
            state_q <= (sts_i.kind == dst_pkg::KIND_INIT) ? S_IDLE : S_SCAN;
          end else begin
            reb_q <= reb_q + 3'd1;
          end
        end
        S_SCAN: begin
          cmp_vld_q  <= issue_vld_q;
          cmp_last_q <= (issue_q == LAST);
          if (issue_vld_q) begin
            if (issue_q == LAST) begin
              issue_vld_q <= 1'b0;
            end else begin
              issue_q <= issue_q + IW'(1);
            end
          end
          if (scan_hit) begin
            state_q <= S_IDLE;
          end else if (cmp_vld_q && cmp_last_q) begin
            state_q <= S_END;
          end
        end
        S_END: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Entry 0 holds the marker and is never scanned
  a_skip_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && issue_vld_q) |-> (issue_q != '0))
    else $error("scan issued a read of the marker entry");

  // Once the last entry has been compared no read is still in flight
  a_last_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cmp_vld_q && cmp_last_q) |-> !issue_vld_q)
    else $error("read issued past the last entry");

  // A finished request returns to idle at once
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == S_IDLE))
    else $error("controller did not return to idle after a result");

endmodule

// File: hw/rtl/device_slot_table.sv
// Top level of the device slot table.
`timescale 1ns / 1ps

// Device slot table. A request is taken when start is high and busy is low;
// exactly one result word follows, shown on status_o, slot_o and is_enabled_o
// for a single cycle while done_o is high. The receiver cannot stall, so the
// result must be captured in that cycle. The entry store is scanned through its
// one read port, one entry a cycle, with a registered read. A register or
// set-status request runs the whole table unless an entry matches first; a
// register request rebuilds the table first when the marker is missing, an init
// request only rebuilds, and the unused kind neither rebuilds nor scans. done_o
// is high in the first cycle in which busy is low again. The rebuild writes the
// marker and slots 1 to 6 and clears the rest through per-entry valid bits, so
// no clearing pass follows reset. The auto registers may be written only while
// busy is low.
module device_slot_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [15:0] device_word_i,
  input  logic        want_enabled_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_o,
  output logic        is_enabled_o
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  dst_pkg::dst_cmd_t cmd;
  dst_pkg::dst_sts_t sts;
  logic [IW-1:0]     rd_addr;
  logic [2:0]        reb_addr;

  dst_controller #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .reb_addr_o (reb_addr)
  );

  dst_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (kind_i),
    .device_word_i  (device_word_i),
    .want_enabled_i (want_enabled_i),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .reb_addr_i     (reb_addr),
    .sts_o          (sts),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .is_enabled_o   (is_enabled_o),
    .done_o         (done_o)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the device slot table.
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_ENTRIES = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int FILL_ITEMS    = 66;
  // Fourth kind code: no operation, reports not found
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    dst_pkg::status_e status;
    logic [5:0]       slot;
    logic             en;
  } outcome_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [2:0]  cfg_index_i    = '0;
  logic [15:0] cfg_data_i     = '0;
  logic        start          = 1'b0;
  logic        busy;
  logic [1:0]  kind_i         = '0;
  logic [15:0] device_word_i  = '0;
  logic        want_enabled_i = 1'b0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [5:0]  slot_o;
  logic        is_enabled_o;

  // Predictor state: table copy and auto registers
  logic [15:0] entry_copy [TABLE_ENTRIES];
  logic [15:0] auto_copy [dst_pkg::NUM_AUTO];
  logic [15:0] auto_plan [dst_pkg::NUM_AUTO];

  outcome_t pending_outcomes [$];
  int       failures    = 0;
  int       cycle_count = 0;
  bit       quiet_phase = 1'b0;
  int       pool_base   = 1;
  int       pool_span   = 16;

  device_slot_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .device_word_i  (device_word_i),
    .want_enabled_i (want_enabled_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .is_enabled_o   (is_enabled_o)
  );

  // Clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("device_slot_table: mismatch");
      $finish;
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin : result_check
    outcome_t exp_o;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result: status %0d slot %0d en %0d",
                 $time, status_o, slot_o, is_enabled_o);
        failures <= failures + 1;
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (status_o !== exp_o.status || slot_o !== exp_o.slot ||
            is_enabled_o !== exp_o.en) begin
          $display("%0t: expected status %0d slot %0d en %0d, got status %0d slot %0d en %0d",
                   $time, exp_o.status, exp_o.slot, exp_o.en,
                   status_o, slot_o, is_enabled_o);
          failures <= failures + 1;
        end
      end
    end
  end

  function automatic int rand_below(int n);
    return $urandom_range(0, n - 1);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [15:0] rand16();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = rand_below(100);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Rebuild: marker, six auto slots, the rest cleared
  function automatic void rebuild_copy();
    int i;
    for (i = 0; i < dst_pkg::NUM_AUTO; i++)
      entry_copy[i + 1] = (auto_copy[i] < dst_pkg::ID_LIMIT) ?
                          (auto_copy[i] | dst_pkg::EN_BIT) : 16'h0000;
    for (i = dst_pkg::NUM_AUTO + 1; i < TABLE_ENTRIES; i++)
      entry_copy[i] = 16'h0000;
    entry_copy[0] = dst_pkg::MARKER;
  endfunction

  // Expected result of one request; updates the table copy
  function automatic outcome_t table_outcome(logic [1:0] kind, logic [15:0] word,
                                              logic want);
    outcome_t o;
    int       i;
    bit       hit;
    o.status = dst_pkg::ST_NOTFOUND;
    o.slot   = '0;
    o.en     = 1'b0;
    hit      = 1'b0;
    case (kind)
      dst_pkg::KIND_REGISTER: begin
        if (entry_copy[0] != dst_pkg::MARKER) rebuild_copy();
        for (i = 1; i < TABLE_ENTRIES && !hit; i++) begin
          if (entry_copy[i][14:0] == word[14:0]) begin
            o.status = dst_pkg::ST_FOUND;
            o.slot   = i[5:0];
            o.en     = entry_copy[i][15];
            hit      = 1'b1;
          end
        end
        for (i = 1; i < TABLE_ENTRIES && !hit; i++) begin
          if (entry_copy[i][14:0] == 15'd0) begin
            entry_copy[i] = {1'b0, word[14:0]};
            o.status = dst_pkg::ST_ALLOC;
            o.slot   = i[5:0];
            hit      = 1'b1;
          end
        end
        if (!hit) o.status = dst_pkg::ST_FULL;
      end
      dst_pkg::KIND_SET: begin
        for (i = 1; i < TABLE_ENTRIES && !hit; i++) begin
          if (entry_copy[i][14:0] == word[14:0]) begin
            entry_copy[i] = want ? (word | dst_pkg::EN_BIT) : word;
            o.status = dst_pkg::ST_SET;
            hit      = 1'b1;
          end
        end
      end
      dst_pkg::KIND_INIT: begin
        rebuild_copy();
        o.status = dst_pkg::ST_INIT;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Send one request word and record its prediction once accepted
  task automatic send_request(input logic [1:0] kind, input logic [15:0] word,
                              input logic want);
    int gap;
    kind_i         <= kind;
    device_word_i  <= word;
    want_enabled_i <= want;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_outcomes.push_back(table_outcome(kind, word, want));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every predicted result has arrived
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0 || busy) @(posedge clk_i);
  endtask

  // Write the selected registers; indices past the autos get random data
  task automatic program_autos(input logic [7:0] which);
    int          i;
    logic [15:0] d;
    wait_idle();
    for (i = 0; i < 8; i++) begin
      if (which[i]) begin
        d = (i < dst_pkg::NUM_AUTO) ? auto_plan[i] : rand16();
        cfg_index_i <= i[2:0];
        cfg_data_i  <= d;
        cfg_we_i    <= 1'b1;
        @(posedge clk_i);
        if (i < dst_pkg::NUM_AUTO) auto_copy[i] = d;
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // Id from the current pool, occasionally zero, random top bit
  function automatic logic [15:0] pool_word();
    int          v;
    logic [15:0] w;
    w = rand16();
    v = (rand_below(16) == 0) ? 0 : pool_base + rand_below(pool_span);
    w[14:0] = v[14:0];
    return w;
  endfunction

  function automatic logic [15:0] pick_auto();
    int          r;
    logic [15:0] w;
    r = rand_below(100);
    w = pool_word();
    if (r < 30) return {1'b0, w[14:0]};
    if (r < 45) begin
      case (rand_below(5))
        0:       return 16'h0000;
        1:       return 16'h7FFE;
        2:       return dst_pkg::ID_LIMIT;
        3:       return dst_pkg::EN_BIT;
        default: return 16'hFFFF;
      endcase
    end
    return rand16();
  endfunction

  // Requests before any rebuild, then the first register rebuilds
  task automatic test_unbuilt_table();
    send_request(dst_pkg::KIND_SET, 16'h0005, 1'b0);
    send_request(dst_pkg::KIND_SET, 16'h0000, 1'b1);
    send_request(KIND_UNUSED, 16'hFFFF, 1'b1);
    send_request(dst_pkg::KIND_REGISTER, 16'hFFFF, 1'b0);
    send_request(dst_pkg::KIND_REGISTER, 16'h0000, 1'b0);
    send_request(dst_pkg::KIND_REGISTER, 16'h7FFF, 1'b1);
  endtask

  // Auto values at the edges, unused register indices, enable handling
  task automatic test_auto_extremes();
    auto_plan[0] = 16'h0000;
    auto_plan[1] = 16'h7FFE;
    auto_plan[2] = dst_pkg::ID_LIMIT;
    auto_plan[3] = 16'hFFFF;
    auto_plan[4] = 16'h8001;
    auto_plan[5] = 16'h5555;
    program_autos(8'hFF);
    send_request(dst_pkg::KIND_INIT, 16'h0000, 1'b0);
    send_request(dst_pkg::KIND_REGISTER, 16'h7FFE, 1'b0);
    send_request(dst_pkg::KIND_REGISTER, 16'h0000, 1'b1);
    send_request(dst_pkg::KIND_REGISTER, 16'hD555, 1'b0);
    // enabled free entry (id zero) gets claimed
    send_request(dst_pkg::KIND_REGISTER, 16'h0001, 1'b0);
    send_request(dst_pkg::KIND_REGISTER, 16'h8001, 1'b0);
    send_request(dst_pkg::KIND_SET, 16'h0001, 1'b1);
    send_request(dst_pkg::KIND_REGISTER, 16'h0001, 1'b0);
    // top bit kept as given when enable not asked for
    send_request(dst_pkg::KIND_SET, 16'hFFFE, 1'b0);
    send_request(dst_pkg::KIND_REGISTER, 16'h7FFE, 1'b0);
    send_request(dst_pkg::KIND_SET, 16'h7FFE, 1'b0);
    send_request(dst_pkg::KIND_REGISTER, 16'h7FFE, 1'b0);
    send_request(dst_pkg::KIND_SET, 16'h1234, 1'b1);
    send_request(dst_pkg::KIND_SET, 16'h0000, 1'b1);
    send_request(KIND_UNUSED, 16'h0000, 1'b0);
  endtask

  // Register fresh ids until the table runs out of free entries
  task automatic test_fill_table();
    int i;
    for (i = 0; i < dst_pkg::NUM_AUTO; i++) auto_plan[i] = 16'(rand_below(32'h7FFF));
    program_autos(8'h3F);
    send_request(dst_pkg::KIND_INIT, rand16(), rand_bit());
    for (i = 0; i < FILL_ITEMS; i++)
      send_request(dst_pkg::KIND_REGISTER, rand16(), rand_bit());
    send_request(dst_pkg::KIND_REGISTER, {1'b1, auto_plan[2][14:0]}, 1'b0);
    send_request(dst_pkg::KIND_SET, rand16(), rand_bit());
  endtask

  // Phases of pooled ids so that hits, claims and full tables all occur
  task automatic test_random_traffic();
    int          issued;
    int          len;
    int          n;
    int          r;
    int          i;
    logic [7:0]  which;
    logic [31:0] rw;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      pool_span = (rand_below(2) == 0) ? 12 : 72;
      pool_base = $urandom_range(1, 32'h7FFF - pool_span);
      for (i = 0; i < dst_pkg::NUM_AUTO; i++) auto_plan[i] = pick_auto();
      rw = $urandom;
      which = (rand_below(3) == 0) ? rw[7:0] : 8'h3F;
      program_autos(which);
      quiet_phase = (rand_below(4) == 0);
      if (rand_below(5) != 0) begin
        send_request(dst_pkg::KIND_INIT, rand16(), rand_bit());
        issued++;
      end
      len = $urandom_range(60, 150);
      for (n = 0; n < len; n++) begin
        r = rand_below(100);
        if (r < 55)
          send_request(dst_pkg::KIND_REGISTER, pool_word(), rand_bit());
        else if (r < 65)
          send_request(dst_pkg::KIND_REGISTER, rand16(), rand_bit());
        else if (r < 85)
          send_request(dst_pkg::KIND_SET, pool_word(), rand_bit());
        else if (r < 90)
          send_request(dst_pkg::KIND_SET, rand16(), rand_bit());
        else if (r < 95)
          send_request(dst_pkg::KIND_INIT, rand16(), rand_bit());
        else
          send_request(KIND_UNUSED, rand16(), rand_bit());
        issued++;
        // sender drains the block now and then
        if (rand_below(50) == 0) wait_idle();
      end
    end
    quiet_phase = 1'b0;
  endtask

  initial begin : run
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++) entry_copy[i] = 16'h0000;
    for (i = 0; i < dst_pkg::NUM_AUTO; i++) auto_copy[i] = dst_pkg::AUTO_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unbuilt_table();
    test_auto_extremes();
    test_fill_table();
    test_random_traffic();

    wait_idle();
    repeat (TABLE_ENTRIES + 16) @(posedge clk_i);
    if (failures == 0)
      $display("device_slot_table: match");
    else
      $display("device_slot_table: mismatch");
    $finish;
  end

endmodule
